// File: sv/ascii_integer_parser_assert.svh
// ----------------------------------------------------------------------------
// ascii_integer_parser_assert.svh
// Assertion macros used by the parser checker.
// ----------------------------------------------------------------------------
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define AIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define AIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared widths, codes, character constants and types of the integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int CharW    = 8;
  localparam int ValueW   = 64;
  localparam int ModeW    = 3;
  localparam int DigitW   = 4;
  localparam int ProdW    = ValueW + DigitW;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 3;

  localparam logic [ModeW-1:0] MODE_S8  = 3'd0;
  localparam logic [ModeW-1:0] MODE_U8  = 3'd1;
  localparam logic [ModeW-1:0] MODE_S16 = 3'd2;
  localparam logic [ModeW-1:0] MODE_U16 = 3'd3;
  localparam logic [ModeW-1:0] MODE_U64 = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_TARGET_MODE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_NUMBER_BASE = 1'b1;

  localparam logic BASE_DEC = 1'b0;
  localparam logic BASE_HEX = 1'b1;

  localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_0     = 8'h30;
  localparam logic [CharW-1:0] CH_9     = 8'h39;
  localparam logic [CharW-1:0] CH_UA    = 8'h41;
  localparam logic [CharW-1:0] CH_UF    = 8'h46;
  localparam logic [CharW-1:0] CH_LA    = 8'h61;
  localparam logic [CharW-1:0] CH_LF    = 8'h66;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             has_char;
    logic             last;
  } beat_t;

  typedef struct packed {
    logic              is_plus;
    logic              is_minus;
    logic              is_digit;
    logic [DigitW-1:0] digit;
  } char_class_t;

  function automatic logic [ValueW-1:0] mode_limit(input logic [ModeW-1:0] mode,
                                                   input logic neg);
    logic [ValueW-1:0] lim;
    case (mode)
      MODE_S8:  lim = neg ? 64'd128 : 64'd127;
      MODE_U8:  lim = 64'd255;
      MODE_S16: lim = neg ? 64'd32768 : 64'd32767;
      MODE_U16: lim = 64'd65535;
      default:  lim = '1;
    endcase
    return lim;
  endfunction

endpackage

// File: sv/aip_char_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_char_decode
// Classifies one character: sign, decimal or hex digit, and its digit value.
// ----------------------------------------------------------------------------
module aip_char_decode (
  input  logic [aip_pkg::CharW-1:0] ch,
  input  logic                      hex,
  output aip_pkg::char_class_t      cls
);

  logic                         is_dec;
  logic                         is_lhex;
  logic                         is_uhex;
  logic [aip_pkg::CharW-1:0]    off_dec;
  logic [aip_pkg::CharW-1:0]    off_lhex;
  logic [aip_pkg::CharW-1:0]    off_uhex;

  always_comb begin
    is_dec   = (ch >= aip_pkg::CH_0)  && (ch <= aip_pkg::CH_9);
    is_lhex  = hex && (ch >= aip_pkg::CH_LA) && (ch <= aip_pkg::CH_LF);
    is_uhex  = hex && (ch >= aip_pkg::CH_UA) && (ch <= aip_pkg::CH_UF);
    off_dec  = ch - aip_pkg::CH_0;
    off_lhex = ch - aip_pkg::CH_LA;
    off_uhex = ch - aip_pkg::CH_UA;

    cls.is_plus  = (ch == aip_pkg::CH_PLUS);
    cls.is_minus = (ch == aip_pkg::CH_MINUS);
    cls.is_digit = is_dec || is_lhex || is_uhex;
    if (is_lhex) begin
      cls.digit = off_lhex[aip_pkg::DigitW-1:0] + 4'd10;
    end else if (is_uhex) begin
      cls.digit = off_uhex[aip_pkg::DigitW-1:0] + 4'd10;
    end else begin
      cls.digit = off_dec[aip_pkg::DigitW-1:0];
    end
  end

endmodule

// File: sv/aip_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_parse_core
// Per-string parse state: accumulate digits, track sign, range and errors,
// and form the result for the closing beat.
// ----------------------------------------------------------------------------
module aip_parse_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  aip_pkg::beat_t             beat,
  input  logic [aip_pkg::ModeW-1:0]  mode,
  input  logic                       base,
  output logic [aip_pkg::ValueW-1:0] res_value,
  output logic                       res_failed
);

  logic [aip_pkg::ValueW-1:0] acc_r, acc_nxt;
  logic                       rng_r, rng_nxt;
  logic                       neg_r, neg_nxt;
  logic                       first_r, first_nxt;
  logic                       need_r, need_nxt;
  logic                       bad_r, bad_nxt;

  logic                       hex;
  logic                       mode_bad;
  aip_pkg::char_class_t       cls;
  logic [aip_pkg::ProdW-1:0]  scaled;
  logic [aip_pkg::ProdW-1:0]  prod;
  logic                       over;

  aip_char_decode u_dec (
    .ch  (beat.ch),
    .hex (hex),
    .cls (cls)
  );

  always_comb begin
    hex      = (mode == aip_pkg::MODE_U16) && (base == aip_pkg::BASE_HEX);
    mode_bad = (mode > aip_pkg::MODE_U64);
    if (hex) begin
      scaled = {acc_r, 4'b0000};
    end else begin
      scaled = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
    end
    prod = scaled + {{(aip_pkg::ProdW-aip_pkg::DigitW){1'b0}}, cls.digit};
    over = prod > {{(aip_pkg::ProdW-aip_pkg::ValueW){1'b0}},
                   aip_pkg::mode_limit(mode, neg_r)};

    acc_nxt   = acc_r;
    rng_nxt   = rng_r;
    neg_nxt   = neg_r;
    first_nxt = first_r;
    need_nxt  = need_r;
    bad_nxt   = bad_r;

    if (beat.has_char) begin
      first_nxt = 1'b0;
      if (mode_bad) begin
        bad_nxt = 1'b1;
      end else if (first_r && cls.is_plus) begin
        first_nxt = 1'b0;
      end else if (first_r && cls.is_minus) begin
        if (mode == aip_pkg::MODE_S8 || mode == aip_pkg::MODE_S16) begin
          neg_nxt = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end else if (!cls.is_digit) begin
        bad_nxt = 1'b1;
      end else begin
        need_nxt = 1'b0;
        if (!rng_r) begin
          if (over) begin
            rng_nxt = 1'b1;
          end else begin
            acc_nxt = prod[aip_pkg::ValueW-1:0];
          end
        end
      end
    end

    res_failed = bad_nxt || rng_nxt || need_nxt || mode_bad;
    if (res_failed) begin
      res_value = '0;
    end else if (neg_nxt) begin
      res_value = {aip_pkg::ValueW{1'b0}} - acc_nxt;
    end else begin
      res_value = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      rng_r   <= 1'b0;
      neg_r   <= 1'b0;
      first_r <= 1'b1;
      need_r  <= 1'b1;
      bad_r   <= 1'b0;
    end else if (go) begin
      if (beat.last) begin
        acc_r   <= '0;
        rng_r   <= 1'b0;
        neg_r   <= 1'b0;
        first_r <= 1'b1;
        need_r  <= 1'b1;
        bad_r   <= 1'b0;
      end else begin
        acc_r   <= acc_nxt;
        rng_r   <= rng_nxt;
        neg_r   <= neg_nxt;
        first_r <= first_nxt;
        need_r  <= need_nxt;
        bad_r   <= bad_nxt;
      end
    end
  end

endmodule

// File: sv/ascii_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Parses a decimal or hex ASCII number string, one character per beat,
// into a signed or unsigned integer of the selected width.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character per beat on in_ch with in_has_char set;
//   in_last marks the final beat of a string. A beat with in_has_char low
//   and in_last high closes an empty string; one with both low is idle.
//   Output channel: one beat per string, out_value (sign-extended in the
//   signed modes, zero on failure) and out_failed.
//   Config: cfg_we writes cfg_wdata into the register at cfg_idx
//   (target mode, number base); write only while no string is in flight.
// Flow:
//   One character per cycle while in_stall is low. A string's result reaches
//   the output register after its last beat is accepted: the beat sits in
//   the input register while the digit/range logic feeds the output register.
// Reset and stall:
//   Reset clears the config, the parse state and both valid flags.
//   While out_stall holds a result, the output beat stays put; in_stall
//   rises only when a closing beat waits behind that held result.
// ----------------------------------------------------------------------------
module ascii_integer_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [aip_pkg::CharW-1:0]    in_ch,
  input  logic                         in_has_char,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [aip_pkg::ValueW-1:0]   out_value,
  output logic                         out_failed,
  input  logic                         cfg_we,
  input  logic [aip_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [aip_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [aip_pkg::ModeW-1:0]  mode_r;
  logic                       base_r;

  logic                       s1_valid_r;
  aip_pkg::beat_t             s1_beat_r;

  logic                       out_valid_r, out_valid_nxt;
  logic [aip_pkg::ValueW-1:0] out_value_r;
  logic                       out_failed_r;

  logic                       out_free;
  logic                       go;
  logic [aip_pkg::ValueW-1:0] res_value;
  logic                       res_failed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= aip_pkg::MODE_S8;
      base_r <= aip_pkg::BASE_DEC;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        aip_pkg::CFG_TARGET_MODE: mode_r <= cfg_wdata[aip_pkg::ModeW-1:0];
        aip_pkg::CFG_NUMBER_BASE: base_r <= cfg_wdata[0];
        default:                  base_r <= base_r;
      endcase
    end
  end

  // advance a beat unless its result has nowhere to go
  assign out_free = !out_valid_r || !out_stall;
  assign go       = s1_valid_r && (!s1_beat_r.last || out_free);
  assign in_stall = s1_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_beat_r.ch       <= in_ch;
      s1_beat_r.has_char <= in_has_char;
      s1_beat_r.last     <= in_last;
    end
  end

  aip_parse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .beat       (s1_beat_r),
    .mode       (mode_r),
    .base       (base_r),
    .res_value  (res_value),
    .res_failed (res_failed)
  );

  always_comb begin
    if (go && s1_beat_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && s1_beat_r.last) begin
      out_value_r  <= res_value;
      out_failed_r <= res_failed;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_failed = out_failed_r;

endmodule

// File: sv/aip_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_checker
// Port-level checks of the integer parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ascii_integer_parser_assert.svh"

module aip_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [aip_pkg::ValueW-1:0] out_value,
  input logic                       out_failed
);

  `AIP_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "out_valid set after reset")
  `AIP_ASSERT(a_fail_zero, out_valid && out_failed |-> out_value == '0, "failed with value")
  `AIP_ASSERT(a_stall_only_blocked, in_stall |-> out_valid && out_stall, "spurious in_stall")
  `AIP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_value), "out beat lost")

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (.*);

// File: test/ascii_integer_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_tb
// Self-checking bench for the ASCII integer parser. Character beats go in with
// random gaps and the result side stalls at random. A scoreboard mirrors the
// parse state and the registers, works out the number or failure for each
// closing beat, and compares every output beat with it. Directed strings hit
// range edges of the defined modes, signs, empty strings and bad characters. A
// random part then runs through many mode and base settings. Most strings there
// are well formed, many near the limits; the rest are broken or noise.
// ----------------------------------------------------------------------------
module ascii_integer_parser_tb;

  localparam logic [aip_pkg::ModeW-1:0] MODE_UNDEF_LO  = 3'd5;
  localparam logic [aip_pkg::ModeW-1:0] MODE_UNDEF_MID = 3'd6;
  localparam logic [aip_pkg::ModeW-1:0] MODE_UNDEF_HI  = 3'd7;
  localparam int                        NUM_PHASES     = 14;
  localparam logic [aip_pkg::ModeW-1:0] PHASE_MODE [NUM_PHASES] = '{
    aip_pkg::MODE_S8, aip_pkg::MODE_U8, aip_pkg::MODE_S16, aip_pkg::MODE_U16,
    aip_pkg::MODE_U16, aip_pkg::MODE_U64, aip_pkg::MODE_U64, aip_pkg::MODE_S8,
    MODE_UNDEF_LO, MODE_UNDEF_HI, MODE_UNDEF_MID, aip_pkg::MODE_U16,
    aip_pkg::MODE_S16, aip_pkg::MODE_U8};
  localparam logic PHASE_BASE [NUM_PHASES] = '{
    aip_pkg::BASE_DEC, aip_pkg::BASE_DEC, aip_pkg::BASE_DEC, aip_pkg::BASE_DEC,
    aip_pkg::BASE_HEX, aip_pkg::BASE_DEC, aip_pkg::BASE_HEX, aip_pkg::BASE_HEX,
    aip_pkg::BASE_DEC, aip_pkg::BASE_HEX, aip_pkg::BASE_DEC, aip_pkg::BASE_HEX,
    aip_pkg::BASE_HEX, aip_pkg::BASE_HEX};

  typedef logic [aip_pkg::CharW-1:0] char_t;

  typedef struct packed {
    logic [aip_pkg::ValueW-1:0] value;
    logic                       failed;
  } number_t;

  class int_parse_checker;
    logic [aip_pkg::ModeW-1:0]  mode;
    logic                       base;
    logic [aip_pkg::ValueW-1:0] acc;
    bit                         over;
    bit                         neg;
    bit                         fresh;
    bit                         no_digit;
    bit                         bad;
    number_t                    expected_numbers[$];
    int                         errors;
    int                         checked;

    function new();
      mode = aip_pkg::MODE_S8;
      base = aip_pkg::BASE_DEC;
      errors = 0;
      checked = 0;
      clear_string();
    endfunction

    function void clear_string();
      acc = '0;
      over = 0;
      neg = 0;
      fresh = 1;
      no_digit = 1;
      bad = 0;
    endfunction

    static function logic [aip_pkg::ValueW-1:0] range_top(
      input logic [aip_pkg::ModeW-1:0] m, input bit n);
      case (m)
        aip_pkg::MODE_S8:  return n ? 64'd128 : 64'd127;
        aip_pkg::MODE_U8:  return 64'd255;
        aip_pkg::MODE_S16: return n ? 64'd32768 : 64'd32767;
        aip_pkg::MODE_U16: return 64'd65535;
        default:           return '1;
      endcase
    endfunction

    function void write_reg(input logic [aip_pkg::CfgIdxW-1:0] idx,
                            input logic [aip_pkg::CfgDataW-1:0] data);
      if (idx == aip_pkg::CFG_TARGET_MODE) mode = data[aip_pkg::ModeW-1:0];
      else base = data[0];
    endfunction

    function void take_char(input char_t c);
      bit                         first;
      bit                         hex;
      logic [aip_pkg::ValueW-1:0] radix;
      logic [aip_pkg::ValueW-1:0] d;
      logic [aip_pkg::ValueW-1:0] lim;
      first = fresh;
      fresh = 0;
      if (mode > aip_pkg::MODE_U64) begin
        bad = 1;
        return;
      end
      if (first && c == aip_pkg::CH_PLUS) return;
      if (first && c == aip_pkg::CH_MINUS) begin
        if (mode == aip_pkg::MODE_S8 || mode == aip_pkg::MODE_S16) neg = 1;
        else bad = 1;
        return;
      end
      hex = (mode == aip_pkg::MODE_U16) && (base == aip_pkg::BASE_HEX);
      radix = hex ? 64'd16 : 64'd10;
      if (c >= aip_pkg::CH_0 && c <= aip_pkg::CH_9) begin
        d = aip_pkg::ValueW'(c - aip_pkg::CH_0);
      end else if (hex && c >= aip_pkg::CH_LA && c <= aip_pkg::CH_LF) begin
        d = aip_pkg::ValueW'(c - aip_pkg::CH_LA) + 64'd10;
      end else if (hex && c >= aip_pkg::CH_UA && c <= aip_pkg::CH_UF) begin
        d = aip_pkg::ValueW'(c - aip_pkg::CH_UA) + 64'd10;
      end else begin
        bad = 1;
        return;
      end
      no_digit = 0;
      if (over) return;
      lim = range_top(mode, neg);
      if (acc > (lim - d) / radix) begin
        over = 1;
        return;
      end
      acc = acc * radix + d;
    endfunction

    function void note_beat(input char_t c, input logic has, input logic is_last);
      number_t e;
      if (has) take_char(c);
      if (!is_last) return;
      e.failed = bad || over || no_digit || (mode > aip_pkg::MODE_U64);
      e.value = e.failed ? '0 : (neg ? '0 - acc : acc);
      expected_numbers.push_back(e);
      clear_string();
    endfunction

    function int pending();
      return expected_numbers.size();
    endfunction

    function void check_result(input logic [aip_pkg::ValueW-1:0] v, input logic f);
      number_t e;
      if (expected_numbers.size() == 0) begin
        $error("unexpected result beat: value=%h failed=%b", v, f);
        errors++;
        return;
      end
      e = expected_numbers.pop_front();
      checked++;
      if (v !== e.value) begin
        $error("value mismatch: expected %h, actual %h", e.value, v);
        errors++;
      end
      if (f !== e.failed) begin
        $error("failed mismatch: expected %b, actual %b", e.failed, f);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [aip_pkg::CharW-1:0]    in_ch;
  logic                         in_has_char;
  logic                         in_last;
  logic                         out_valid;
  logic                         out_stall;
  logic [aip_pkg::ValueW-1:0]   out_value;
  logic                         out_failed;
  logic                         cfg_we;
  logic [aip_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [aip_pkg::CfgDataW-1:0] cfg_wdata;

  int_parse_checker          chk;
  char_t                     word[$];
  logic [aip_pkg::ModeW-1:0] cur_mode;
  logic                      cur_base;
  bit                        calm;
  int                        stall_left;
  int                        strings_sent;
  int                        beats_sent;
  int                        settings_used;

  ascii_integer_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .in_has_char(in_has_char),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_failed (out_failed),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      case ($urandom_range(0, 99)) inside
        [0:24]:  stall_left = $urandom_range(1, 3);
        [25:27]: stall_left = $urandom_range(10, 30);
        default: stall_left = 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) chk.check_result(out_value, out_failed);
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic char_t odd_char();
    case ($urandom_range(0, 13))
      0:       return aip_pkg::CH_PLUS;
      1:       return aip_pkg::CH_MINUS;
      2:       return aip_pkg::CH_0;
      3:       return aip_pkg::CH_9;
      4:       return aip_pkg::CH_UA;
      5:       return aip_pkg::CH_UF;
      6:       return aip_pkg::CH_LA;
      7:       return aip_pkg::CH_LF;
      8:       return aip_pkg::CH_0 - 8'd1;
      9:       return aip_pkg::CH_9 + 8'd1;
      10:      return aip_pkg::CH_UA - 8'd1;
      11:      return aip_pkg::CH_UF + 8'd1;
      12:      return aip_pkg::CH_LA - 8'd1;
      default: return aip_pkg::CH_LF + 8'd1;
    endcase
  endfunction

  function automatic void push_number(input logic [aip_pkg::ValueW-1:0] v, input bit hex);
    char_t                      digits[$];
    logic [aip_pkg::ValueW-1:0] radix;
    logic [aip_pkg::ValueW-1:0] d;
    radix = hex ? 64'd16 : 64'd10;
    do begin
      d = v % radix;
      if (d < 10) begin
        digits.push_front(aip_pkg::CH_0 + d[aip_pkg::CharW-1:0]);
      end else if ($urandom_range(0, 1)) begin
        digits.push_front(aip_pkg::CH_LA + d[aip_pkg::CharW-1:0] - 8'd10);
      end else begin
        digits.push_front(aip_pkg::CH_UA + d[aip_pkg::CharW-1:0] - 8'd10);
      end
      v = v / radix;
    end while (v != 0);
    foreach (digits[i]) word.push_back(digits[i]);
  endfunction

  function automatic void load_text(input string t);
    word.delete();
    for (int i = 0; i < t.len(); i++) word.push_back(t[i]);
  endfunction

  function automatic void make_word();
    bit                         hex;
    bit                         sgn;
    bit                         minus;
    int                         r;
    logic [aip_pkg::ValueW-1:0] lim;
    word.delete();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(0, 6))
        word.push_back($urandom_range(0, 1) ? odd_char() : char_t'($urandom_range(0, 255)));
      return;
    end
    hex = (cur_mode == aip_pkg::MODE_U16) && (cur_base == aip_pkg::BASE_HEX);
    sgn = (cur_mode == aip_pkg::MODE_S8) || (cur_mode == aip_pkg::MODE_S16);
    minus = 0;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      word.push_back(aip_pkg::CH_PLUS);
    end else if (r < 5 && (sgn || $urandom_range(0, 3) == 0)) begin
      word.push_back(aip_pkg::CH_MINUS);
      minus = 1;
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) word.push_back(aip_pkg::CH_0);
    lim = int_parse_checker::range_top(cur_mode, minus && sgn);
    case ($urandom_range(0, 3))
      0: push_number(aip_pkg::ValueW'($urandom_range(0, 300)), hex);
      1: push_number(lim - aip_pkg::ValueW'($urandom_range(0, 3)), hex);
      2: begin
        if (lim == '1) begin
          push_number(lim, hex);
          word.push_back(aip_pkg::CH_0 + char_t'($urandom_range(0, 9)));
        end else begin
          push_number(lim + aip_pkg::ValueW'($urandom_range(1, 3)), hex);
        end
      end
      default: push_number({$urandom, $urandom} >> $urandom_range(0, 63), hex);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) begin
        word[$urandom_range(0, word.size() - 1)] = char_t'($urandom_range(0, 255));
      end else if (word.size() >= 2) begin
        word.insert($urandom_range(1, word.size() - 1), aip_pkg::CH_MINUS);
      end else begin
        word.push_back(aip_pkg::CH_MINUS);
      end
    end
  endfunction

  task automatic send_beat(input char_t c, input logic has, input logic is_last);
    repeat (pick_gap()) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_ch       <= c;
    in_has_char <= has;
    in_last     <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_beat(c, has, is_last);
    if (has || is_last) beats_sent++;
  endtask

  task automatic send_word(input bit split_close, input int idle_pct);
    bit sep;
    sep = split_close || (word.size() == 0);
    foreach (word[i]) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        send_beat(char_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_beat(word[i], 1'b1, !sep && (i == word.size() - 1));
    end
    if (sep) send_beat(char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string t);
    load_text(t);
    send_word(1'b0, 0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chk.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [aip_pkg::ModeW-1:0] m, input logic b);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= aip_pkg::CFG_TARGET_MODE;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_idx   <= aip_pkg::CFG_NUMBER_BASE;
    cfg_wdata <= {{(aip_pkg::CfgDataW - 1){1'b0}}, b};
    @(negedge clk);
    cfg_we <= 1'b0;
    chk.write_reg(aip_pkg::CFG_TARGET_MODE, m);
    chk.write_reg(aip_pkg::CFG_NUMBER_BASE, {{(aip_pkg::CfgDataW - 1){1'b0}}, b});
    cur_mode = m;
    cur_base = b;
    settings_used++;
  endtask

  initial begin
    int budget;
    int start_beats;
    chk = new();
    cur_mode = aip_pkg::MODE_S8;
    cur_base = aip_pkg::BASE_DEC;
    calm = 0;
    stall_left = 0;
    strings_sent = 0;
    beats_sent = 0;
    settings_used = 1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ch = '0;
    in_has_char = 1'b0;
    in_last = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: signed 8-bit, decimal
    send_text("127");
    send_text("128");
    send_text("-128");
    send_text("-129");
    send_text("-0");
    load_text("+5");
    send_word(1'b1, 100);
    send_text("");
    send_text("-");
    send_text("1-");
    send_text("12a");
    set_cfg(aip_pkg::MODE_U8, aip_pkg::BASE_DEC);
    send_text("255");
    send_text("256");
    send_text("-1");
    set_cfg(aip_pkg::MODE_S16, aip_pkg::BASE_DEC);
    send_text("32767");
    send_text("-32768");
    send_text("32768");
    set_cfg(aip_pkg::MODE_U16, aip_pkg::BASE_HEX);
    send_text("ffff");
    send_text("FFFF");
    send_text("10000");
    set_cfg(aip_pkg::MODE_U16, aip_pkg::BASE_DEC);
    send_text("65535");
    send_text("65536");
    set_cfg(aip_pkg::MODE_U64, aip_pkg::BASE_HEX);
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    send_text("a");
    set_cfg(MODE_UNDEF_HI, aip_pkg::BASE_DEC);
    send_text("1");

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_cfg(PHASE_MODE[p], PHASE_BASE[p]);
      calm = (p % 4 == 1);
      budget = (PHASE_MODE[p] > aip_pkg::MODE_U64) ? 40 : 160;
      start_beats = beats_sent;
      while (beats_sent - start_beats < budget) begin
        make_word();
        send_word($urandom_range(0, 9) < 3, 5);
      end
    end

    calm = 0;
    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d strings in %0d beats across %0d register settings.",
             strings_sent, beats_sent, settings_used);
    $display("Checked %0d results, %0d mismatches.", chk.checked, chk.errors);
    if (chk.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: ascii_integer_parser.f
+incdir+sv
sv/aip_pkg.sv
sv/aip_char_decode.sv
sv/aip_parse_core.sv
sv/ascii_integer_parser.sv
sv/aip_checker.sv
test/ascii_integer_parser_tb.sv
